/* hw/rtl/lhp_pkg.sv */
// Shared types and constants for the LCT header parser.
// No dependencies; imported by every module of the block.
package lhp_pkg;

  localparam int QueueDepth = 4;

  localparam logic [1:0] KIND_HDR   = 2'd0;
  localparam logic [1:0] KIND_EXT   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] CFG_ATSC3 = 2'd0;
  localparam logic [1:0] CFG_FDT   = 2'd1;
  localparam logic [1:0] CFG_CENC  = 2'd2;

  localparam logic [7:0] EXT_CC    = 8'd3;
  localparam logic [7:0] EXT_TOL48 = 8'd67;
  localparam logic [7:0] EXT_SEND_RATE   = 8'd128;
  localparam logic [7:0] EXT_FDT   = 8'd192;
  localparam logic [7:0] EXT_CONTENT_ENC = 8'd193;
  localparam logic [7:0] EXT_TOL24 = 8'd194;
  localparam logic [7:0] EXT_VARLEN_MAX = 8'd127;

  typedef enum logic [2:0] {
    PH_FIXED   = 3'b001,
    PH_WALK    = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef struct packed {
    logic       win;
    logic [3:0] lo;
    logic [3:0] hi;
  } window_t;

  // One queue entry: header snapshot plus an optional record and an
  // optional trailing error record.
  typedef struct packed {
    logic        has_rec;
    logic        has_trunc;
    logic [1:0]  kind;
    logic [7:0]  ext_type;
    logic [63:0] ext_value;
    logic        last;
    logic [7:0]  code_point;
    logic [5:0]  status;
    logic [9:0]  header_bytes;
    logic [47:0] session_id;
    logic [63:0] object_low;
    logic [47:0] object_high;
    logic [31:0] sender_time;
    logic [31:0] residual_time;
  } entry_t;

  function automatic window_t ext_window(input logic [7:0] t);
    window_t w;
    w = '{win: 1'b1, lo: 4'd0, hi: 4'd0};
    case (t)
      EXT_CC:          begin w.lo = 4'd2; w.hi = 4'd9; end
      EXT_TOL48:       begin w.lo = 4'd2; w.hi = 4'd7; end
      EXT_SEND_RATE:   begin w.lo = 4'd2; w.hi = 4'd3; end
      EXT_FDT:         begin w.lo = 4'd0; w.hi = 4'd3; end
      EXT_CONTENT_ENC: begin w.lo = 4'd3; w.hi = 4'd3; end
      EXT_TOL24:       begin w.lo = 4'd1; w.hi = 4'd3; end
      default:   w.win = 1'b0;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/lhp_front.sv */
// Front end: takes packet bytes, tracks the header layout and builds queue entries.
// Depends on lhp_pkg.
module lhp_front import lhp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_take,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  output logic        push,
  output entry_t      push_entry
);

  logic        atsc_r, fdt_en_r, cenc_en_r;
  phase_t      phase_r, phase_nxt;
  logic [9:0]  bp_r, bp_nxt;
  logic [15:0] flag_r, flag_nxt;
  logic [9:0]  hlen_r, hlen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [47:0] tsi_r, tsi_nxt;
  logic [63:0] tol_r, tol_nxt;
  logic [47:0] toh_r, toh_nxt;
  logic [31:0] sct_r, sct_nxt;
  logic [31:0] ert_r, ert_nxt;
  logic [7:0]  cp_r, cp_nxt;
  logic [9:0]  xstart_r, xstart_nxt;
  logic [7:0]  xtype_r, xtype_nxt;
  logic [9:0]  xlen_r, xlen_nxt;
  logic        fdt_r, fdt_nxt;

  logic [5:0]  a_end, tsi_len, toi_len, k_end, fix_len;
  logic [9:0]  rel, sh;
  logic [10:0] x_end;
  logic        abort;
  window_t     w;
  logic        has_rec, has_trunc, last;
  logic [1:0]  kind;
  logic [63:0] ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atsc_r    <= 1'b0;
      fdt_en_r  <= 1'b0;
      cenc_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATSC3: atsc_r    <= cfg_data;
        CFG_FDT:   fdt_en_r  <= cfg_data;
        CFG_CENC:  cenc_en_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    a_end   = 6'd8 + {2'b0, flag_r[11:10], 2'b0};
    tsi_len = {3'b0, flag_r[7], 2'b0} + {4'b0, flag_r[4], 1'b0};
    toi_len = {2'b0, flag_r[6:5], 2'b0} + {4'b0, flag_r[4], 1'b0};
    k_end   = a_end + tsi_len + toi_len;
    fix_len = k_end + {3'b0, flag_r[3], 2'b0} + {3'b0, flag_r[2], 2'b0};
  end

  always_comb begin
    phase_nxt = phase_r; bp_nxt = bp_r; flag_nxt = flag_r; hlen_nxt = hlen_r;
    acc_nxt = acc_r; tsi_nxt = tsi_r; tol_nxt = tol_r; toh_nxt = toh_r;
    sct_nxt = sct_r; ert_nxt = ert_r; cp_nxt = cp_r; xstart_nxt = xstart_r;
    xtype_nxt = xtype_r; xlen_nxt = xlen_r; fdt_nxt = fdt_r;
    has_rec = 1'b0; has_trunc = 1'b0; kind = KIND_HDR; last = 1'b0; ev = '0;
    rel = bp_r - xstart_r; abort = 1'b0; w = ext_window(xtype_r); sh = '0;
    x_end = '0;
    if (byte_take) begin
      unique case (phase_r)
        PH_FIXED: begin
          bp_nxt = bp_r + 10'd1;
          if (bp_r == 10'd0) begin
            hlen_nxt = '0; acc_nxt = '0; tsi_nxt = '0; tol_nxt = '0; toh_nxt = '0;
            sct_nxt = '0; ert_nxt = '0; cp_nxt = '0; xstart_nxt = '0;
            xtype_nxt = '0; xlen_nxt = '0; fdt_nxt = 1'b0;
            flag_nxt = {packet_byte, 8'h00};
          end else if (bp_r == 10'd1) begin
            flag_nxt = {flag_r[15:8], packet_byte};
          end else if (bp_r == 10'd2) begin
            hlen_nxt = {packet_byte, 2'b00};
          end else if (bp_r == 10'd3) begin
            cp_nxt = packet_byte;
          end else begin
            if (bp_r < {4'b0, a_end}) begin
            end else if (bp_r < {4'b0, a_end + tsi_len}) begin
              tsi_nxt = {tsi_r[39:0], packet_byte};
            end else if (bp_r < {4'b0, k_end}) begin
              toh_nxt = {toh_r[39:0], tol_r[63:56]};
              tol_nxt = {tol_r[55:0], packet_byte};
            end else if (flag_r[3] && bp_r < {4'b0, k_end + 6'd4}) begin
              sct_nxt = {sct_r[23:0], packet_byte};
            end else if (flag_r[2]) begin
              ert_nxt = {ert_r[23:0], packet_byte};
            end
            if (bp_r + 10'd1 == {4'b0, fix_len}) begin
              has_rec = 1'b1;
              if (hlen_r > {4'b0, fix_len}) begin
                xstart_nxt = {4'b0, fix_len}; xlen_nxt = '0; phase_nxt = PH_WALK;
              end else begin
                phase_nxt = PH_PAYLOAD; last = 1'b1;
              end
            end
          end
        end
        PH_WALK: begin
          bp_nxt = bp_r + 10'd1;
          if (rel == 10'd0) begin
            xtype_nxt = packet_byte; acc_nxt = '0;
            xlen_nxt = (packet_byte > EXT_VARLEN_MAX) ? 10'd4 : 10'd0;
          end else if (rel == 10'd1 && xtype_r <= EXT_VARLEN_MAX) begin
            xlen_nxt = {packet_byte, 2'b00};
            if (packet_byte == 8'd0) abort = 1'b1;
          end
          x_end = {1'b0, xstart_r} + {1'b0, xlen_nxt};
          if (!abort && (rel == 10'd0 || rel == 10'd1) && xlen_nxt != 10'd0 &&
              x_end > {1'b0, hlen_r}) begin
            abort = 1'b1;
          end
          if (abort) begin
            has_rec = 1'b1; kind = KIND_ERROR; last = 1'b1; phase_nxt = PH_PAYLOAD;
          end else begin
            w = ext_window(xtype_nxt);
            if (w.win && rel >= {6'b0, w.lo} && rel <= {6'b0, w.hi}) begin
              acc_nxt = {acc_nxt[55:0], packet_byte};
            end
            if (xlen_nxt != 10'd0 && {1'b0, rel} + 11'd1 == {1'b0, xlen_nxt}) begin
              has_rec = 1'b1; kind = KIND_EXT;
              ev = {54'b0, xlen_nxt};
              if (w.win) begin
                if (xlen_nxt < {6'b0, w.hi} + 10'd1) begin
                  sh = {6'b0, w.hi} + 10'd1 - xlen_nxt;
                end
                ev = acc_nxt << {sh[2:0], 3'b000};
                if (xtype_nxt == EXT_FDT) begin
                  if (fdt_en_r) begin
                    ev = {40'b0, ev[23:0]}; fdt_nxt = 1'b1;
                  end else begin
                    ev = {54'b0, xlen_nxt};
                  end
                end else if (xtype_nxt == EXT_CONTENT_ENC && !cenc_en_r) begin
                  ev = {54'b0, xlen_nxt};
                end
              end
              if (x_end >= {1'b0, hlen_r}) begin
                phase_nxt = PH_PAYLOAD; last = 1'b1;
              end else begin
                xstart_nxt = x_end[9:0]; xlen_nxt = '0;
              end
            end
          end
        end
        PH_PAYLOAD: ;
        default: ;
      endcase
      if (end_of_packet) begin
        if (phase_nxt != PH_PAYLOAD) has_trunc = 1'b1;
        phase_nxt = PH_FIXED;
        bp_nxt = '0;
      end
    end
  end

  always_comb begin
    push = has_rec | has_trunc;
    push_entry.has_rec       = has_rec;
    push_entry.has_trunc     = has_trunc;
    push_entry.kind          = kind;
    push_entry.ext_type      = (kind == KIND_EXT) ? xtype_nxt : 8'd0;
    push_entry.ext_value     = ev;
    push_entry.last          = last;
    push_entry.code_point    = cp_nxt;
    push_entry.status        = {fdt_nxt, atsc_r & flag_nxt[9], flag_nxt[2],
                                flag_nxt[3], flag_nxt[0], flag_nxt[1]};
    push_entry.header_bytes  = hlen_nxt;
    push_entry.session_id    = tsi_nxt;
    push_entry.object_low    = tol_nxt;
    push_entry.object_high   = toh_nxt;
    push_entry.sender_time   = sct_nxt;
    push_entry.residual_time = ert_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIXED; bp_r <= '0; flag_r <= '0; hlen_r <= '0; acc_r <= '0;
      tsi_r <= '0; tol_r <= '0; toh_r <= '0; sct_r <= '0; ert_r <= '0; cp_r <= '0;
      xstart_r <= '0; xtype_r <= '0; xlen_r <= '0; fdt_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; bp_r <= bp_nxt; flag_r <= flag_nxt; hlen_r <= hlen_nxt;
      acc_r <= acc_nxt; tsi_r <= tsi_nxt; tol_r <= tol_nxt; toh_r <= toh_nxt;
      sct_r <= sct_nxt; ert_r <= ert_nxt; cp_r <= cp_nxt; xstart_r <= xstart_nxt;
      xtype_r <= xtype_nxt; xlen_r <= xlen_nxt; fdt_r <= fdt_nxt;
    end
  end

endmodule

/* hw/rtl/lhp_queue.sv */
// Short entry queue between the front end and the record emitter.
// Depends on lhp_pkg.
module lhp_queue import lhp_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_r [Depth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [CntW-1:0]   cnt_r;

  assign full  = (cnt_r == CntW'(Depth));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* hw/rtl/lhp_back.sv */
// Record emitter: expands queue entries into one or two output records.
// Depends on lhp_pkg.
module lhp_back import lhp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  entry_t q_head,
  output logic   pop,
  input  logic   out_stall,
  output logic   out_valid,
  output entry_t cur,
  output logic   show_error
);

  logic   valid_r;
  entry_t cur_r;
  logic   trunc_r;
  logic   take, final_rec;

  assign take      = valid_r && !out_stall;
  assign final_rec = trunc_r || !cur_r.has_trunc;
  assign pop       = !q_empty && (!valid_r || (take && final_rec));

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0; trunc_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1; trunc_r <= !q_head.has_rec;
    end else if (take) begin
      // advance to the trailing error record, or drop the entry
      if (final_rec) valid_r <= 1'b0;
      else trunc_r <= 1'b1;
    end
  end

  assign out_valid  = valid_r;
  assign cur        = cur_r;
  assign show_error = trunc_r;

endmodule

/* hw/rtl/lct_header_parser_unit.sv */
// LCT header parser top level: front end, entry queue, record emitter.
// A byte's records pass through the entry queue and then the emitter's output register.
// Throughput: one byte per cycle while the entry queue is not full; a byte ending in both
// a record and an error record gives two output records, absorbed by the entry queue.
// Reset (rst_n low, synchronous) clears registers, queue and parser state.
module lct_header_parser_unit import lhp_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_record_kind,
  output logic [7:0]  out_code_point,
  output logic [5:0]  out_status_flags,
  output logic [9:0]  out_header_bytes,
  output logic [47:0] out_session_id,
  output logic [63:0] out_object_id_low,
  output logic [47:0] out_object_id_high,
  output logic [31:0] out_sender_time_ms,
  output logic [31:0] out_residual_time_ms,
  output logic [7:0]  out_extension_type,
  output logic [63:0] out_extension_value,
  output logic        out_last_of_header,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);

  logic   q_full, q_empty, push, pop, take, show_error;
  entry_t push_entry, head, cur;

  assign in_stall  = q_full;
  assign take      = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  lhp_front u_front (
    .clk, .rst_n,
    .byte_take     (take),
    .packet_byte   (in_packet_byte),
    .end_of_packet (in_end_of_packet),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index, .cfg_data,
    .push, .push_entry
  );

  lhp_queue #(.Depth(QDepth)) u_queue (
    .clk, .rst_n, .push, .push_entry, .pop,
    .full (q_full), .empty (q_empty), .head
  );

  lhp_back u_back (
    .clk, .rst_n, .q_empty, .q_head (head), .pop,
    .out_stall, .out_valid, .cur, .show_error
  );

  assign out_record_kind      = show_error ? KIND_ERROR : cur.kind;
  assign out_code_point       = cur.code_point;
  assign out_status_flags     = cur.status;
  assign out_header_bytes     = cur.header_bytes;
  assign out_session_id       = cur.session_id;
  assign out_object_id_low    = cur.object_low;
  assign out_object_id_high   = cur.object_high;
  assign out_sender_time_ms   = cur.sender_time;
  assign out_residual_time_ms = cur.residual_time;
  assign out_extension_type   = show_error ? 8'd0 : cur.ext_type;
  assign out_extension_value  = show_error ? 64'd0 : cur.ext_value;
  assign out_last_of_header   = show_error ? 1'b1 : cur.last;

endmodule

/* verif/lct_header_parser_unit_checker.sv */
`timescale 1ns / 1ps
// Checker for the LCT header parser: watches the byte, record and register channels.
// Predicts the records of every accepted byte and compares them in order; needs lhp_pkg.
module lct_header_parser_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_end_of_packet,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_record_kind,
  input  logic [7:0]  out_code_point,
  input  logic [5:0]  out_status_flags,
  input  logic [9:0]  out_header_bytes,
  input  logic [47:0] out_session_id,
  input  logic [63:0] out_object_id_low,
  input  logic [47:0] out_object_id_high,
  input  logic [31:0] out_sender_time_ms,
  input  logic [31:0] out_residual_time_ms,
  input  logic [7:0]  out_extension_type,
  input  logic [63:0] out_extension_value,
  input  logic        out_last_of_header,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data,
  output int          fail_count,
  output int          pending_records,
  output int          matched_records
);

  typedef enum logic [1:0] {SCAN_FIXED, SCAN_EXT, SCAN_BODY} scan_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  code_point;
    logic [5:0]  status;
    logic [9:0]  header_bytes;
    logic [47:0] session_id;
    logic [63:0] object_low;
    logic [47:0] object_high;
    logic [31:0] sender_time;
    logic [31:0] residual_time;
    logic [7:0]  ext_type;
    logic [63:0] ext_value;
    logic        last;
  } record_t;

  record_t record_q[$];

  logic        atsc3_on, fdt_on, cenc_on;
  logic [9:0]  pos, hlen, xstart, xlen;
  logic [15:0] fw;
  logic [63:0] acc, olo;
  logic [47:0] sid, ohi;
  logic [31:0] sct, ert;
  logic [7:0]  cp, xtype;
  scan_t       scan;
  logic        fdt_seen;

  assign pending_records = record_q.size();

  function automatic int fixed_len();
    int h;
    h = fw[4];
    return 4 + (int'(fw[11:10]) * 4 + 4) + fw[7] * 4 + h * 2 + int'(fw[6:5]) * 4 + h * 2
           + fw[3] * 4 + fw[2] * 4;
  endfunction

  task automatic push_record(logic [1:0] kind, logic [7:0] et, logic [63:0] ev, logic last);
    record_t r;
    r.kind = kind;
    r.code_point = cp;
    r.status = {fdt_seen, atsc3_on & fw[9], fw[2], fw[3], fw[0], fw[1]};
    r.header_bytes = hlen;
    r.session_id = sid;
    r.object_low = olo;
    r.object_high = ohi;
    r.sender_time = sct;
    r.residual_time = ert;
    r.ext_type = et;
    r.ext_value = ev;
    r.last = last;
    record_q.push_back(r);
  endtask

  task automatic clear_packet();
    pos = '0; fw = '0; hlen = '0; xstart = '0; xtype = '0; xlen = '0;
    scan = SCAN_FIXED; fdt_seen = 1'b0; cp = '0; acc = '0; sid = '0;
    olo = '0; ohi = '0; sct = '0; ert = '0;
  endtask

  task automatic fixed_byte(logic [7:0] b);
    int p, h, a, tsi, toi, k, f;
    p = pos;
    pos = pos + 10'd1;
    if (p == 0) begin
      clear_packet();
      pos = 10'd1;
      fw = {b, 8'h00};
    end else if (p == 1) begin
      fw[7:0] = b;
    end else if (p == 2) begin
      hlen = {b, 2'b00};
    end else if (p == 3) begin
      cp = b;
    end else begin
      h = fw[4];
      a = 4 + int'(fw[11:10]) * 4 + 4;
      tsi = fw[7] * 4 + h * 2;
      toi = int'(fw[6:5]) * 4 + h * 2;
      k = a + tsi + toi;
      if (p < a) begin
      end else if (p < a + tsi) begin
        sid = {sid[39:0], b};
      end else if (p < k) begin
        ohi = {ohi[39:0], olo[63:56]};
        olo = {olo[55:0], b};
      end else begin
        if (fw[3]) begin
          if (p < k + 4) sct = {sct[23:0], b};
          k += 4;
        end
        if (fw[2] && p >= k && p < k + 4) ert = {ert[23:0], b};
      end
      f = fixed_len();
      if (p + 1 == f) begin
        if (int'(hlen) > f) begin
          xstart = f[9:0];
          xlen = '0;
          scan = SCAN_EXT;
          push_record(lhp_pkg::KIND_HDR, 8'd0, 64'd0, 1'b0);
        end else begin
          scan = SCAN_BODY;
          push_record(lhp_pkg::KIND_HDR, 8'd0, 64'd0, 1'b1);
        end
      end
    end
  endtask

  task automatic ext_byte(logic [7:0] b);
    logic [9:0]  rel;
    int          lo, hi, n, len, nxt;
    logic        win;
    logic [63:0] v;
    rel = pos - xstart;
    pos = pos + 10'd1;
    win = 1'b1;
    lo = 0;
    hi = 0;
    if (rel == 0) begin
      xtype = b; acc = '0; xlen = '0;
      if (b > lhp_pkg::EXT_VARLEN_MAX) xlen = 10'd4;
    end else if (rel == 1 && xtype <= lhp_pkg::EXT_VARLEN_MAX) begin
      xlen = {b, 2'b00};
      if (xlen == 0) begin
        scan = SCAN_BODY;
        push_record(lhp_pkg::KIND_ERROR, 8'd0, 64'd0, 1'b1);
        return;
      end
    end
    if (rel <= 1 && xlen != 0 && int'(xstart) + int'(xlen) > int'(hlen)) begin
      scan = SCAN_BODY;
      push_record(lhp_pkg::KIND_ERROR, 8'd0, 64'd0, 1'b1);
      return;
    end
    case (xtype)
      lhp_pkg::EXT_CC:          begin lo = 2; hi = 9; end
      lhp_pkg::EXT_TOL48:       begin lo = 2; hi = 7; end
      lhp_pkg::EXT_SEND_RATE:   begin lo = 2; hi = 3; end
      lhp_pkg::EXT_FDT:         begin lo = 0; hi = 3; end
      lhp_pkg::EXT_CONTENT_ENC: begin lo = 3; hi = 3; end
      lhp_pkg::EXT_TOL24:       begin lo = 1; hi = 3; end
      default:            win = 1'b0;
    endcase
    if (win && rel >= lo && rel <= hi) acc = {acc[55:0], b};
    len = xlen;
    if (len == 0 || int'(rel) + 1 != len) return;
    v = len;
    if (win) begin
      n = ((len < hi + 1) ? len : hi + 1) - lo;
      v = acc << (8 * (hi + 1 - lo - n));
      if (xtype == lhp_pkg::EXT_FDT) begin
        if (fdt_on) begin
          v &= 64'h00FF_FFFF;
          fdt_seen = 1'b1;
        end else begin
          v = len;
        end
      end else if (xtype == lhp_pkg::EXT_CONTENT_ENC && !cenc_on) begin
        v = len;
      end
    end
    nxt = int'(xstart) + len;
    if (nxt >= int'(hlen)) begin
      scan = SCAN_BODY;
      push_record(lhp_pkg::KIND_EXT, xtype, v, 1'b1);
    end else begin
      xstart = nxt[9:0];
      xlen = '0;
      push_record(lhp_pkg::KIND_EXT, xtype, v, 1'b0);
    end
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    record_t e;
    if (!rst_n) begin
      atsc3_on = 1'b0; fdt_on = 1'b0; cenc_on = 1'b0;
      clear_packet();
      record_q.delete();
      fail_count = 0;
      matched_records = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lhp_pkg::CFG_ATSC3: atsc3_on = cfg_data;
          lhp_pkg::CFG_FDT:   fdt_on = cfg_data;
          lhp_pkg::CFG_CENC:  cenc_on = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (scan == SCAN_FIXED) fixed_byte(in_packet_byte);
        else if (scan == SCAN_EXT) ext_byte(in_packet_byte);
        if (in_end_of_packet) begin
          if (scan != SCAN_BODY) push_record(lhp_pkg::KIND_ERROR, 8'd0, 64'd0, 1'b1);
          scan = SCAN_FIXED;
          pos = '0;
        end
      end
      if (out_valid && !out_stall) begin
        if (record_q.size() == 0) begin
          fail_count++;
          $display("%0t: record with no expectation: expected none, actual kind %0d", $time,
                   out_record_kind);
        end else begin
          e = record_q.pop_front();
          matched_records++;
          check_field("record_kind", e.kind, out_record_kind);
          check_field("code_point", e.code_point, out_code_point);
          check_field("status_flags", e.status, out_status_flags);
          check_field("header_bytes", e.header_bytes, out_header_bytes);
          check_field("session_id", e.session_id, out_session_id);
          check_field("object_id_low", e.object_low, out_object_id_low);
          check_field("object_id_high", e.object_high, out_object_id_high);
          check_field("sender_time_ms", e.sender_time, out_sender_time_ms);
          check_field("residual_time_ms", e.residual_time, out_residual_time_ms);
          check_field("extension_type", e.ext_type, out_extension_type);
          check_field("extension_value", e.ext_value, out_extension_value);
          check_field("last_of_header", e.last, out_last_of_header);
        end
      end
    end
  end

endmodule

/* verif/lct_header_parser_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the LCT header parser: clock, reset, packet stimulus and verdict.
// Depends on lhp_pkg, lct_header_parser_unit and lct_header_parser_unit_checker.
module lct_header_parser_unit_tb;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 12;

  typedef enum int {PKT_GOOD, PKT_NOISE, PKT_TRUNC, PKT_ZERO_LEN, PKT_BAD_HLEN} pkt_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte = '0;
  logic        in_end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_record_kind;
  logic [7:0]  out_code_point;
  logic [5:0]  out_status_flags;
  logic [9:0]  out_header_bytes;
  logic [47:0] out_session_id;
  logic [63:0] out_object_id_low;
  logic [47:0] out_object_id_high;
  logic [31:0] out_sender_time_ms;
  logic [31:0] out_residual_time_ms;
  logic [7:0]  out_extension_type;
  logic [63:0] out_extension_value;
  logic        out_last_of_header;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic        cfg_data = 1'b0;

  int fail_count, pending_records, matched_records;
  int cycle = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  bit quiet = 1'b0;
  logic [7:0] pkt[$];

  lct_header_parser_unit DUT (.*);

  lct_header_parser_unit_checker checker_i (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet window, and one long hold-off to back up the block.
  always @(posedge clk) begin
    if (cycle >= 800 && cycle < 1200) out_stall <= 1'b1;
    else if (cycle >= 1300 && cycle < 1700) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 13);
  end

  task automatic send_byte(logic [7:0] b, logic eop);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_packet_byte <= b;
    in_end_of_packet <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Build one packet; flags < 0 and next < 0 mean random, xtype < 0 picks a random type.
  task automatic build_packet(pkt_kind_t kind, int flags, int next, int xtype);
    logic [15:0] fw;
    int f, n, t, w, hl, cut;
    pkt.delete();
    if (kind == PKT_NOISE) begin
      repeat ($urandom_range(40, 1)) pkt.push_back(8'($urandom_range(255)));
      return;
    end
    fw = (flags < 0) ? 16'($urandom) : 16'(flags);
    f = 4 + int'(fw[11:10]) * 4 + 4 + fw[7] * 4 + fw[4] * 4 + int'(fw[6:5]) * 4
        + fw[3] * 4 + fw[2] * 4;
    pkt.push_back(fw[15:8]);
    pkt.push_back(fw[7:0]);
    pkt.push_back(8'd0);
    pkt.push_back(8'($urandom_range(255)));
    repeat (f - 4) pkt.push_back(8'($urandom_range(255)));
    n = (next < 0) ? $urandom_range(3) : next;
    for (int i = 0; i < n; i++) begin
      if (xtype >= 0 && i == 0) t = xtype;
      else begin
        case ($urandom_range(7))
          0: t = lhp_pkg::EXT_CC;
          1: t = lhp_pkg::EXT_TOL48;
          2: t = lhp_pkg::EXT_SEND_RATE;
          3: t = lhp_pkg::EXT_FDT;
          4: t = lhp_pkg::EXT_CONTENT_ENC;
          5: t = lhp_pkg::EXT_TOL24;
          6: t = $urandom_range(127);
          default: t = $urandom_range(255, 128);
        endcase
      end
      pkt.push_back(8'(t));
      if (t <= lhp_pkg::EXT_VARLEN_MAX) begin
        w = (kind == PKT_ZERO_LEN && i == 0) ? 0 : $urandom_range(4, 1);
        pkt.push_back(8'(w));
        repeat ((w == 0) ? 2 : 4 * w - 2) pkt.push_back(8'($urandom_range(255)));
      end else begin
        repeat (3) pkt.push_back(8'($urandom_range(255)));
      end
    end
    hl = pkt.size();
    pkt[2] = (kind == PKT_BAD_HLEN) ? 8'($urandom_range(255)) : 8'(hl / 4);
    repeat ($urandom_range(6)) pkt.push_back(8'($urandom_range(255)));
    if (kind == PKT_TRUNC) begin
      cut = $urandom_range(hl - 1, 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  task automatic set_regs(logic a, logic f, logic c);
    cfg_write(lhp_pkg::CFG_ATSC3, a);
    cfg_write(lhp_pkg::CFG_FDT, f);
    cfg_write(lhp_pkg::CFG_CENC, c);
  endtask

  initial begin
    int r;
    logic [2:0] regs;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: flag extremes, every extension type, error cases, short header.
    set_regs(1'b1, 1'b1, 1'b1);
    build_packet(PKT_GOOD, 16'h0000, 0, -1); send_packet();
    build_packet(PKT_GOOD, 16'hFFFF, 0, -1); send_packet();
    build_packet(PKT_GOOD, 16'hFFFF, 1, lhp_pkg::EXT_CC); send_packet();
    build_packet(PKT_GOOD, 16'h0200, 1, lhp_pkg::EXT_TOL48); send_packet();
    build_packet(PKT_GOOD, 16'h0010, 1, lhp_pkg::EXT_SEND_RATE); send_packet();
    build_packet(PKT_GOOD, 16'h0C80, 1, lhp_pkg::EXT_FDT); send_packet();
    build_packet(PKT_GOOD, 16'h0060, 1, lhp_pkg::EXT_CONTENT_ENC); send_packet();
    build_packet(PKT_GOOD, 16'h000F, 2, lhp_pkg::EXT_TOL24); send_packet();
    build_packet(PKT_ZERO_LEN, -1, 1, 5); send_packet();
    build_packet(PKT_BAD_HLEN, -1, 2, -1); send_packet();
    build_packet(PKT_TRUNC, -1, 2, -1); send_packet();
    wait_idle();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: regs = 3'b000;
        1: regs = 3'b111;
        2: regs = 3'b101;
        3: regs = 3'b010;
        default: regs = 3'($urandom);
      endcase
      set_regs(regs[2], regs[1], regs[0]);
      quiet = (ph == 3);
      r = bytes_sent + 200;
      while (bytes_sent < r) begin
        case ($urandom_range(19))
          0: build_packet(PKT_NOISE, -1, -1, -1);
          1: build_packet(PKT_TRUNC, -1, -1, -1);
          2: build_packet(PKT_ZERO_LEN, -1, -1, $urandom_range(127));
          3: build_packet(PKT_BAD_HLEN, -1, -1, -1);
          default: build_packet(PKT_GOOD, -1, -1, -1);
        endcase
        send_packet();
      end
      wait_idle();
    end

    $display("Sent %0d packets (%0d bytes) over six register settings; %0d records compared.",
             packets_sent, bytes_sent, matched_records);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
